// ===== src/touch_gesture_classifier_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the touch gesture classifier
// Clocked implication checks, reset-qualified, reporting through $error.
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TGC_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define TGC_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/tgc_pkg.sv =====
// ---------------------------------------------------------------------------
// tgc_pkg
// Widths, codes and shared types of the touch gesture classifier.
// ---------------------------------------------------------------------------
package tgc_pkg;

  // Internal precision
  localparam int COORD_WIDTH = 12;
  localparam int TIME_WIDTH  = 32;

  // Fixed field widths
  localparam int OP_W        = 3;
  localparam int RAW_W       = 16;
  localparam int STAMP_W     = 32;
  localparam int GST_W       = 3;
  localparam int POINT_W     = 12;
  localparam int SIZE_W      = 12;
  localparam int PMAX_W      = 16;
  localparam int MIN_DIST_W  = 12;
  localparam int MAX_TIME_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Derived widths
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int CMP_W   = COORD_WIDTH + 2;
  localparam int DIST_W  = (COORD_WIDTH > MIN_DIST_W) ? COORD_WIDTH : MIN_DIST_W;
  localparam int STEP_W  = $clog2(SIZE_W);

  // Event opcodes
  localparam logic [OP_W-1:0] OP_ABS_X  = 3'd0;
  localparam logic [OP_W-1:0] OP_ABS_Y  = 3'd1;
  localparam logic [OP_W-1:0] OP_BUTTON = 3'd2;
  localparam logic [OP_W-1:0] OP_SYNC   = 3'd3;

  // Gesture codes
  localparam logic [GST_W-1:0] GST_NONE  = 3'd0;
  localparam logic [GST_W-1:0] GST_TAP   = 3'd1;
  localparam logic [GST_W-1:0] GST_RIGHT = 3'd2;
  localparam logic [GST_W-1:0] GST_LEFT  = 3'd3;
  localparam logic [GST_W-1:0] GST_DOWN  = 3'd4;
  localparam logic [GST_W-1:0] GST_UP    = 3'd5;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_MAX_X   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_MAX_Y   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SWIPE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TIME      = 3'd5;

  // Scaling job handed to the serial scaler
  typedef struct packed {
    logic [RAW_W-1:0]    raw;
    logic [SIZE_W-1:0]   screen;
    logic [PMAX_W-1:0]   pmax;
  } scale_req_t;

  // Classification job handed to the classifier
  typedef struct packed {
    logic [COORD_WIDTH-1:0] cur_x;
    logic [COORD_WIDTH-1:0] cur_y;
    logic [COORD_WIDTH-1:0] start_x;
    logic [COORD_WIDTH-1:0] start_y;
    logic [TIME_WIDTH-1:0]  press_time;
    logic [TIME_WIDTH-1:0]  now;
  } cls_req_t;

endpackage

// ===== src/tgc_in_if.sv =====
// ---------------------------------------------------------------------------
// tgc_in_if
// Touch event channel: valid/ready handshake with opcode, value and stamp.
// ---------------------------------------------------------------------------
interface tgc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tgc_pkg::OP_W-1:0]    opcode;
  logic [tgc_pkg::RAW_W-1:0]   raw_value;
  logic [tgc_pkg::STAMP_W-1:0] time_ms;

  modport source (output valid, opcode, raw_value, time_ms, input ready);
  modport sink   (input valid, opcode, raw_value, time_ms, output ready);
endinterface

// ===== src/tgc_out_if.sv =====
// ---------------------------------------------------------------------------
// tgc_out_if
// Gesture result channel: valid/ready handshake with gesture and tap point.
// ---------------------------------------------------------------------------
interface tgc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tgc_pkg::GST_W-1:0]   gesture;
  logic [tgc_pkg::POINT_W-1:0] point_x;
  logic [tgc_pkg::POINT_W-1:0] point_y;

  modport source (output valid, gesture, point_x, point_y, input ready);
  modport sink   (input valid, gesture, point_x, point_y, output ready);
endinterface

// ===== src/tgc_scaler.sv =====
// ---------------------------------------------------------------------------
// tgc_scaler
// Bit-serial clamp, multiply and divide: floor(min(raw,pmax)*screen/pmax).
// ---------------------------------------------------------------------------
module tgc_scaler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  tgc_pkg::scale_req_t                 req,
  output logic                                done,
  output logic [tgc_pkg::COORD_WIDTH-1:0]     result
);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_DIV  = 2'd2;
  localparam logic [1:0] SC_DONE = 2'd3;

  localparam logic [tgc_pkg::STEP_W-1:0] LAST_STEP =
    tgc_pkg::STEP_W'(tgc_pkg::SIZE_W - 1);

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [tgc_pkg::STEP_W-1:0]      step;
  logic [tgc_pkg::RAW_W:0]         hi;
  logic [tgc_pkg::RAW_W:0]         hi_next;
  logic [tgc_pkg::SIZE_W-1:0]      lo;
  logic [tgc_pkg::SIZE_W-1:0]      lo_next;
  logic [tgc_pkg::RAW_W-1:0]       mcand;
  logic [tgc_pkg::PMAX_W-1:0]      divisor;
  logic                            zero_div;
  logic [tgc_pkg::RAW_W-1:0]       raw_clamped;
  logic [tgc_pkg::RAW_W:0]         sum;
  logic [tgc_pkg::RAW_W:0]         trial;
  logic                            fits;

  // Clamp raw value to the panel maximum
  assign raw_clamped = (req.raw > req.pmax) ? req.pmax : req.raw;

  // One multiplier bit or one quotient bit per cycle
  always_comb begin
    sum     = hi + ((lo[0]) ? {1'b0, mcand} : '0);
    trial   = {hi[tgc_pkg::RAW_W-1:0], lo[tgc_pkg::SIZE_W-1]};
    fits    = (trial >= {1'b0, divisor});
    hi_next = hi;
    lo_next = lo;
    unique case (state)
      SC_MUL: begin
        hi_next = {1'b0, sum[tgc_pkg::RAW_W:1]};
        lo_next = {sum[0], lo[tgc_pkg::SIZE_W-1:1]};
      end
      SC_DIV: begin
        hi_next = fits ? (trial - {1'b0, divisor}) : trial;
        lo_next = {lo[tgc_pkg::SIZE_W-2:0], fits};
      end
      default: ;
    endcase
  end

  // Sequence multiply then divide phases
  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (start) state_next = SC_MUL;
      SC_MUL:  if (step == LAST_STEP) state_next = SC_DIV;
      SC_DIV:  if (step == LAST_STEP) state_next = SC_DONE;
      SC_DONE: state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == SC_MUL || state == SC_DIV) begin
        step <= (step == LAST_STEP) ? '0 : step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  // Load operands on start, then shift
  always_ff @(posedge clk) begin
    if (state == SC_IDLE && start) begin
      hi       <= '0;
      lo       <= req.screen;
      mcand    <= raw_clamped;
      divisor  <= req.pmax;
      zero_div <= (req.pmax == '0);
    end else begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

  assign done   = (state == SC_DONE);
  assign result = zero_div ? '0 : tgc_pkg::COORD_WIDTH'(lo);

endmodule

// ===== src/tgc_classifier.sv =====
// ---------------------------------------------------------------------------
// tgc_classifier
// Short pipeline that turns a finished press into a gesture result beat.
// ---------------------------------------------------------------------------
module tgc_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 launch,
  input  tgc_pkg::cls_req_t                    req,
  input  logic [tgc_pkg::MIN_DIST_W-1:0]       min_swipe_distance,
  input  logic [tgc_pkg::MAX_TIME_W-1:0]       max_swipe_time,
  output logic                                 idle,
  tgc_out_if.source                            result
);

  logic                              s0_valid;
  logic [tgc_pkg::DIFF_W-1:0]        dx;
  logic [tgc_pkg::DIFF_W-1:0]        dy;
  logic [tgc_pkg::TIME_WIDTH-1:0]    elapsed;
  logic [tgc_pkg::COORD_WIDTH-1:0]   sx;
  logic [tgc_pkg::COORD_WIDTH-1:0]   sy;

  logic                              s1_valid;
  logic [tgc_pkg::GST_W-1:0]         s1_gesture;
  logic [tgc_pkg::POINT_W-1:0]       s1_px;
  logic [tgc_pkg::POINT_W-1:0]       s1_py;

  logic [tgc_pkg::DIFF_W-1:0]        ndx;
  logic [tgc_pkg::DIFF_W-1:0]        ndy;
  logic [tgc_pkg::COORD_WIDTH-1:0]   ax;
  logic [tgc_pkg::COORD_WIDTH-1:0]   ay;
  logic                              tap;
  logic                              slow;
  logic                              horiz;
  logic                              vert;
  logic                              dx_pos;
  logic                              dy_pos;
  logic [tgc_pkg::GST_W-1:0]         gesture_c;
  logic                              s1_load;
  logic                              out_load;

  assign s1_load  = s0_valid && !s1_valid;
  assign out_load = s1_valid && (!result.valid || result.ready);
  assign idle     = !s0_valid && !s1_valid;

  // Magnitudes, thresholds and direction
  always_comb begin
    ndx    = -dx;
    ndy    = -dy;
    ax     = tgc_pkg::COORD_WIDTH'(dx[tgc_pkg::DIFF_W-1] ? ndx : dx);
    ay     = tgc_pkg::COORD_WIDTH'(dy[tgc_pkg::DIFF_W-1] ? ndy : dy);
    dx_pos = !dx[tgc_pkg::DIFF_W-1] && (dx != '0);
    dy_pos = !dy[tgc_pkg::DIFF_W-1] && (dy != '0);
    tap    = (tgc_pkg::DIST_W'(ax) < tgc_pkg::DIST_W'(min_swipe_distance)) &&
             (tgc_pkg::DIST_W'(ay) < tgc_pkg::DIST_W'(min_swipe_distance));
    slow   = elapsed > tgc_pkg::TIME_WIDTH'(max_swipe_time);
    horiz  = tgc_pkg::CMP_W'({ax, 1'b0}) >
             (tgc_pkg::CMP_W'({ay, 1'b0}) + tgc_pkg::CMP_W'(ay));
    vert   = tgc_pkg::CMP_W'({ay, 1'b0}) >
             (tgc_pkg::CMP_W'({ax, 1'b0}) + tgc_pkg::CMP_W'(ax));
    if (tap) begin
      gesture_c = tgc_pkg::GST_TAP;
    end else if (slow) begin
      gesture_c = tgc_pkg::GST_NONE;
    end else if (horiz) begin
      gesture_c = dx_pos ? tgc_pkg::GST_RIGHT : tgc_pkg::GST_LEFT;
    end else if (vert) begin
      gesture_c = dy_pos ? tgc_pkg::GST_DOWN : tgc_pkg::GST_UP;
    end else begin
      gesture_c = tgc_pkg::GST_NONE;
    end
  end

  // Stage valid flags and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (launch) begin
        s0_valid <= 1'b1;
      end else if (s1_load) begin
        s0_valid <= 1'b0;
      end
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Capture differences on launch
  always_ff @(posedge clk) begin
    if (launch) begin
      dx      <= {1'b0, req.cur_x} - {1'b0, req.start_x};
      dy      <= {1'b0, req.cur_y} - {1'b0, req.start_y};
      elapsed <= req.now - req.press_time;
      sx      <= req.start_x;
      sy      <= req.start_y;
    end
  end

  // Hold the decided gesture until the output slot frees
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_gesture <= gesture_c;
      s1_px      <= tap ? tgc_pkg::POINT_W'(sx) : '0;
      s1_py      <= tap ? tgc_pkg::POINT_W'(sy) : '0;
    end
    if (out_load) begin
      result.gesture <= s1_gesture;
      result.point_x <= s1_px;
      result.point_y <= s1_py;
    end
  end

endmodule

// ===== src/touch_gesture_classifier.sv =====
// ---------------------------------------------------------------------------
// touch_gesture_classifier
// Touch event framing, coordinate scaling and tap/swipe classification.
// ---------------------------------------------------------------------------
// Takes one touch event per beat on evt and emits at most one gesture beat on
// result, on the release frame that ends a press. An X or Y event is clamped
// and scaled by a bit-serial unit that runs 12 shift-add multiply steps and 12
// restoring divide steps, one bit each, and a new event is taken only after
// the scaled value is stored. A button event, an ignored opcode or a sync
// that ends no press does not hold up the next event; one that ends a press
// does until the classifier is empty and takes the press. Its gesture then
// passes the difference, decision and result registers. While a result beat
// waits to be taken, one more finished press is held inside the classifier,
// so events keep flowing up to the second press-ending sync that follows.
// Registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`include "touch_gesture_classifier_assert.svh"

module touch_gesture_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tgc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_data,
  tgc_in_if.sink                            evt,
  tgc_out_if.source                         result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_CLASS = 2'd2;

  // Configuration registers
  logic [tgc_pkg::SIZE_W-1:0]       screen_width;
  logic [tgc_pkg::SIZE_W-1:0]       screen_height;
  logic [tgc_pkg::PMAX_W-1:0]       panel_max_x;
  logic [tgc_pkg::PMAX_W-1:0]       panel_max_y;
  logic [tgc_pkg::MIN_DIST_W-1:0]   min_swipe_distance;
  logic [tgc_pkg::MAX_TIME_W-1:0]   max_swipe_time;

  // Gesture state
  logic [1:0]                       state;
  logic                             awaiting_release;
  logic                             touch_down;
  logic                             frame_changed;
  logic                             axis_y;
  logic [tgc_pkg::COORD_WIDTH-1:0]  current_x;
  logic [tgc_pkg::COORD_WIDTH-1:0]  current_y;
  logic [tgc_pkg::COORD_WIDTH-1:0]  start_x;
  logic [tgc_pkg::COORD_WIDTH-1:0]  start_y;
  logic [tgc_pkg::TIME_WIDTH-1:0]   press_time;
  logic [tgc_pkg::TIME_WIDTH-1:0]   sync_time;

  logic                             accept;
  logic [tgc_pkg::TIME_WIDTH-1:0]   now;
  logic                             scl_start;
  tgc_pkg::scale_req_t              scl_req;
  logic                             scl_done;
  logic [tgc_pkg::COORD_WIDTH-1:0]  scl_result;
  logic                             cls_launch;
  logic                             cls_idle;
  tgc_pkg::cls_req_t                cls_req;

  assign evt.ready = (state == ST_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign now       = tgc_pkg::TIME_WIDTH'(evt.time_ms);

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width       <= tgc_pkg::SIZE_W'(800);
      screen_height      <= tgc_pkg::SIZE_W'(480);
      panel_max_x        <= tgc_pkg::PMAX_W'(4095);
      panel_max_y        <= tgc_pkg::PMAX_W'(4095);
      min_swipe_distance <= tgc_pkg::MIN_DIST_W'(50);
      max_swipe_time     <= tgc_pkg::MAX_TIME_W'(400);
    end else if (cfg_write) begin
      unique case (cfg_index)
        tgc_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[tgc_pkg::SIZE_W-1:0];
        tgc_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[tgc_pkg::SIZE_W-1:0];
        tgc_pkg::REG_PANEL_MAX_X:   panel_max_x   <= cfg_data;
        tgc_pkg::REG_PANEL_MAX_Y:   panel_max_y   <= cfg_data;
        tgc_pkg::REG_MIN_SWIPE:
          min_swipe_distance <= cfg_data[tgc_pkg::MIN_DIST_W-1:0];
        tgc_pkg::REG_MAX_TIME:      max_swipe_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // Start scaling on a coordinate beat
  assign scl_start      = accept &&
                          (evt.opcode == tgc_pkg::OP_ABS_X || evt.opcode == tgc_pkg::OP_ABS_Y);
  assign scl_req.raw    = evt.raw_value;
  assign scl_req.screen = (evt.opcode == tgc_pkg::OP_ABS_Y) ? screen_height : screen_width;
  assign scl_req.pmax   = (evt.opcode == tgc_pkg::OP_ABS_Y) ? panel_max_y : panel_max_x;

  tgc_scaler u_scaler (
    .clk    (clk),
    .rst    (rst),
    .start  (scl_start),
    .req    (scl_req),
    .done   (scl_done),
    .result (scl_result)
  );

  // Hand a finished press to the classifier
  assign cls_launch         = (state == ST_CLASS) && cls_idle;
  assign cls_req.cur_x      = current_x;
  assign cls_req.cur_y      = current_y;
  assign cls_req.start_x    = start_x;
  assign cls_req.start_y    = start_y;
  assign cls_req.press_time = press_time;
  assign cls_req.now        = sync_time;

  tgc_classifier u_classifier (
    .clk                (clk),
    .rst                (rst),
    .launch             (cls_launch),
    .req                (cls_req),
    .min_swipe_distance (min_swipe_distance),
    .max_swipe_time     (max_swipe_time),
    .idle               (cls_idle),
    .result             (result)
  );

  // Frame tracking and press/release sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      awaiting_release <= 1'b0;
      touch_down       <= 1'b0;
      frame_changed    <= 1'b0;
      axis_y           <= 1'b0;
      current_x        <= '0;
      current_y        <= '0;
      start_x          <= '0;
      start_y          <= '0;
      press_time       <= '0;
      sync_time        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (evt.opcode) inside
              tgc_pkg::OP_ABS_X, tgc_pkg::OP_ABS_Y: begin
                axis_y        <= (evt.opcode == tgc_pkg::OP_ABS_Y);
                frame_changed <= 1'b1;
                state         <= ST_SCALE;
              end
              tgc_pkg::OP_BUTTON: begin
                touch_down    <= (evt.raw_value != '0);
                frame_changed <= 1'b1;
              end
              tgc_pkg::OP_SYNC: begin
                if (frame_changed) begin
                  frame_changed <= 1'b0;
                  if (!awaiting_release && touch_down) begin
                    start_x          <= current_x;
                    start_y          <= current_y;
                    press_time       <= now;
                    awaiting_release <= 1'b1;
                  end else if (awaiting_release && !touch_down) begin
                    awaiting_release <= 1'b0;
                    sync_time        <= now;
                    state            <= ST_CLASS;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCALE: begin
          if (scl_done) begin
            if (axis_y) begin
              current_y <= scl_result;
            end else begin
              current_x <= scl_result;
            end
            state <= ST_IDLE;
          end
        end
        ST_CLASS: begin
          if (cls_launch) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `TGC_ASSERT_NXT(a_coord_scales, clk, rst, scl_start, state == ST_SCALE)
  `TGC_ASSERT_IMP(a_done_in_scale, clk, rst, scl_done, state == ST_SCALE)
  `TGC_ASSERT_IMP(a_launch_idle, clk, rst, cls_launch, cls_idle && !awaiting_release)
  `TGC_ASSERT_IMP(a_point_only_tap, clk, rst,
                  result.valid && result.gesture != tgc_pkg::GST_TAP,
                  result.point_x == '0 && result.point_y == '0)

endmodule

// ===== test/tb_touch_gesture_classifier.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_touch_gesture_classifier
// Feeds touch event streams into the gesture classifier: press and release
// frames with random content, broken frames and raw noise. The stream runs
// under several register settings, the extremes among them. A scoreboard
// predicts every gesture beat and compares it field by field with what the
// block emits. Random gaps and stalls are applied on both channels.
// ---------------------------------------------------------------------------
module tb_touch_gesture_classifier;
  import tgc_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_GAP       = 18;
  localparam int PHASE_ITEMS   = 140;

  // Opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_IGNORED_LO = 3'd4;
  localparam logic [OP_W-1:0] OP_IGNORED_HI = 3'd7;

  typedef struct packed {
    logic [GST_W-1:0]   gesture;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
  } gesture_t;

  // Tracks the frame and press state and holds the gestures still to come
  class gesture_book;
    logic [SIZE_W-1:0]      scr_w, scr_h;
    logic [PMAX_W-1:0]      pmax_x, pmax_y;
    logic [MIN_DIST_W-1:0]  min_dist;
    logic [MAX_TIME_W-1:0]  max_time;
    bit                     armed, pressed, dirty;
    logic [COORD_WIDTH-1:0] cur_x, cur_y, start_x, start_y;
    logic [TIME_WIDTH-1:0]  start_ms;
    gesture_t               gestures_due[$];
    int                     errors;

    function new();
      scr_w    = 800;
      scr_h    = 480;
      pmax_x   = 4095;
      pmax_y   = 4095;
      min_dist = 50;
      max_time = 400;
      armed    = 0;
      pressed  = 0;
      dirty    = 0;
      cur_x    = '0;
      cur_y    = '0;
      start_x  = '0;
      start_y  = '0;
      start_ms = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w    = data[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: scr_h    = data[SIZE_W-1:0];
        REG_PANEL_MAX_X:   pmax_x   = data[PMAX_W-1:0];
        REG_PANEL_MAX_Y:   pmax_y   = data[PMAX_W-1:0];
        REG_MIN_SWIPE:     min_dist = data[MIN_DIST_W-1:0];
        REG_MAX_TIME:      max_time = data[MAX_TIME_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp to the panel range, then floor(raw * screen / panel_max)
    function logic [COORD_WIDTH-1:0] to_pixels(logic [RAW_W-1:0] raw,
                                               logic [SIZE_W-1:0] screen,
                                               logic [PMAX_W-1:0] pmax);
      logic [RAW_W+SIZE_W-1:0] clamped;
      logic [RAW_W+SIZE_W-1:0] quot;
      if (pmax == 0) return '0;
      clamped = (raw > pmax) ? pmax : raw;
      quot = (clamped * screen) / pmax;
      return quot[COORD_WIDTH-1:0];
    endfunction

    // Note an accepted event; a release frame queues the gesture it ends
    function void take_event(logic [OP_W-1:0] op, logic [RAW_W-1:0] raw,
                             logic [STAMP_W-1:0] stamp);
      int dx, dy, ax, ay;
      logic [TIME_WIDTH-1:0] elapsed;
      gesture_t g;
      case (op)
        OP_ABS_X: begin
          cur_x = to_pixels(raw, scr_w, pmax_x);
          dirty = 1;
        end
        OP_ABS_Y: begin
          cur_y = to_pixels(raw, scr_h, pmax_y);
          dirty = 1;
        end
        OP_BUTTON: begin
          pressed = (raw != 0);
          dirty = 1;
        end
        OP_SYNC: begin
          if (dirty) begin
            dirty = 0;
            if (!armed) begin
              if (pressed) begin
                start_x  = cur_x;
                start_y  = cur_y;
                start_ms = stamp;
                armed    = 1;
              end
            end else if (!pressed) begin
              armed = 0;
              dx = int'(cur_x) - int'(start_x);
              dy = int'(cur_y) - int'(start_y);
              ax = (dx < 0) ? -dx : dx;
              ay = (dy < 0) ? -dy : dy;
              elapsed = stamp - start_ms;
              g = '0;
              g.gesture = GST_NONE;
              if (ax < min_dist && ay < min_dist) begin
                g.gesture = GST_TAP;
                g.point_x = start_x;
                g.point_y = start_y;
              end else if (elapsed > max_time) begin
                g.gesture = GST_NONE;
              end else if (2 * ax > 3 * ay) begin
                g.gesture = (dx > 0) ? GST_RIGHT : GST_LEFT;
              end else if (2 * ay > 3 * ax) begin
                g.gesture = (dy > 0) ? GST_DOWN : GST_UP;
              end
              gestures_due.push_back(g);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one gesture beat with the oldest one due
    function void check_gesture(gesture_t got);
      gesture_t want;
      if (gestures_due.size() == 0) begin
        $error("unexpected gesture beat: gesture=%0d point_x=%0d point_y=%0d",
               got.gesture, got.point_x, got.point_y);
        errors++;
        return;
      end
      want = gestures_due.pop_front();
      if (got.gesture !== want.gesture) begin
        $error("gesture: expected %0d, got %0d", want.gesture, got.gesture);
        errors++;
      end
      if (got.point_x !== want.point_x) begin
        $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== want.point_y) begin
        $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  tgc_in_if  evt_ch ();
  tgc_out_if res_ch ();

  gesture_book book;
  int          items_sent = 0;
  int          quiet = 0;
  bit          sender_calm = 0;
  bit          sink_calm = 0;

  // Settings: width, height, panel max X, panel max Y, min distance, max time
  int unsigned presets [7][6] = '{
    '{800,  480,  4095,  4095,  50,   400},
    '{4095, 4095, 65535, 65535, 4095, 65535},
    '{1,    1,    1,     1,     0,    0},
    '{4095, 4095, 1000,  1000,  0,    65535},
    '{1920, 1080, 65535, 65535, 100,  1000},
    '{320,  240,  4095,  4095,  8,    300},
    '{1024, 600,  255,   65535, 30,   150}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_gesture_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_ch),
    .result    (res_ch)
  );

  // Drop valid when no beat follows right away
  task automatic hold_events();
    @(negedge clk);
    evt_ch.valid = 1'b0;
  endtask

  // Wait out a random gap, present one event and hold it until taken
  task automatic send_event(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
                            input logic [STAMP_W-1:0] stamp);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      evt_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_ch.valid     = 1'b1;
    evt_ch.opcode    = op;
    evt_ch.raw_value = raw;
    evt_ch.time_ms   = stamp;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    book.take_event(op, raw, stamp);
    items_sent++;
  endtask

  // Stop sending until every gesture due has been taken
  task automatic drain_gestures();
    hold_events();
    while (book.gestures_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
    book.set_reg(idx, cfg_data);
  endtask

  // Let the block go idle, then load a full register set
  task automatic configure(input int unsigned sw, input int unsigned sh,
                           input int unsigned px, input int unsigned py,
                           input int unsigned md, input int unsigned mt);
    drain_gestures();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_PANEL_MAX_X, px);
    write_reg(REG_PANEL_MAX_Y, py);
    write_reg(REG_MIN_SWIPE, md);
    write_reg(REG_MAX_TIME, mt);
  endtask

  // One frame: optional coordinates, button level and ignored opcode, then sync
  task automatic send_frame(input int unsigned x, input int unsigned y,
                            input bit with_button, input bit level,
                            input logic [STAMP_W-1:0] stamp);
    bit button_first;
    bit y_first;
    button_first = 1'($urandom_range(0, 1));
    y_first = 1'($urandom_range(0, 1));
    if (with_button && button_first)
      send_event(OP_BUTTON, level ? 16'($urandom_range(1, 65535)) : 16'h0, $urandom());
    if (y_first && $urandom_range(0, 9) != 0) send_event(OP_ABS_Y, y[RAW_W-1:0], $urandom());
    if ($urandom_range(0, 9) != 0) send_event(OP_ABS_X, x[RAW_W-1:0], $urandom());
    if (!y_first && $urandom_range(0, 9) != 0) send_event(OP_ABS_Y, y[RAW_W-1:0], $urandom());
    if (with_button && !button_first)
      send_event(OP_BUTTON, level ? 16'($urandom_range(1, 65535)) : 16'h0, $urandom());
    if ($urandom_range(0, 9) == 0)
      send_event(OP_W'(OP_IGNORED_LO + $urandom_range(0, OP_IGNORED_HI - OP_IGNORED_LO)),
                 RAW_W'($urandom()), $urandom());
    send_event(OP_SYNC, RAW_W'($urandom()), stamp);
  endtask

  // Move a raw coordinate by a near or far step, kept within 16 bits
  function automatic int unsigned shift_coord(int unsigned from, int unsigned span, bit far);
    int unsigned d;
    d = far ? $urandom_range(span / 8, span / 2) : $urandom_range(0, span / 32);
    if ($urandom_range(0, 1)) return (from + d > 65535) ? 65535 : from + d;
    return (d > from) ? 0 : from - d;
  endfunction

  // Press, optional moves, release: tap, swipe, diagonal or slow
  task automatic play_gesture();
    int unsigned span_x, span_y, sx, sy, ex, ey, dur, t0, moves;
    bit far_x, far_y;
    int kind;
    span_x = (book.pmax_x == 0) ? 65535 : book.pmax_x;
    span_y = (book.pmax_y == 0) ? 65535 : book.pmax_y;
    kind = $urandom_range(0, 4);
    far_x = (kind == 1 || kind == 3) || (kind == 4 && $urandom_range(0, 1));
    far_y = (kind == 2 || kind == 3) || (kind == 4 && $urandom_range(0, 1));
    sx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span_x);
    sy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span_y);
    ex = shift_coord(sx, span_x, far_x);
    ey = shift_coord(sy, span_y, far_y);
    case ($urandom_range(0, 9))
      0:       dur = 32'(book.max_time);
      1:       dur = 32'(book.max_time) + 1;
      2:       dur = $urandom();
      default: dur = $urandom_range(0, book.max_time);
    endcase
    t0 = $urandom();
    if ($urandom_range(0, 7) == 0) t0 = 32'hFFFF_FFFF - $urandom_range(0, dur);
    send_frame(sx, sy, 1, 1, t0);
    moves = $urandom_range(0, 2);
    for (int m = 1; m <= moves; m++) begin
      // a repeated press while held must not restart the gesture
      send_frame((sx + ex) / 2, (sy + ey) / 2, $urandom_range(0, 7) == 0, 1,
                 t0 + dur / (moves + 1) * m);
    end
    send_frame(ex, ey, 1, 0, t0 + dur);
  endtask

  // Frames out of order, empty syncs and raw noise
  task automatic play_noise();
    case ($urandom_range(0, 3))
      0: send_frame($urandom(), $urandom(), 1, 1'($urandom_range(0, 1)), $urandom());
      1: send_event(OP_SYNC, RAW_W'($urandom()), $urandom());
      2: send_frame($urandom(), $urandom(), 0, 0, $urandom());
      default: begin
        repeat ($urandom_range(1, 6))
          send_event(OP_W'($urandom_range(0, 7)), RAW_W'($urandom()), $urandom());
      end
    endcase
  endtask

  task automatic run_phase();
    int target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 7) == 0) sender_calm = !sender_calm;
      if ($urandom_range(0, 39) == 0) drain_gestures();
      if ($urandom_range(0, 99) < 80) play_gesture();
      else play_noise();
    end
  endtask

  task automatic run_directed();
    // ignored opcodes, empty frame, release while idle
    send_event(OP_IGNORED_LO, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(OP_IGNORED_HI, 16'h5A5A, 32'h0);
    send_event(OP_SYNC, 16'h0, 32'd10);
    send_event(OP_BUTTON, 16'h0, 32'd20);
    send_event(OP_SYNC, 16'h0, 32'd30);
    // press at the origin, press again while held, release at the far X edge
    send_event(OP_ABS_X, 16'h0, 32'd90);
    send_event(OP_ABS_Y, 16'h0, 32'd90);
    send_event(OP_BUTTON, 16'h1, 32'd90);
    send_event(OP_SYNC, 16'h0, 32'd100);
    send_event(OP_BUTTON, 16'h8000, 32'd110);
    send_event(OP_SYNC, 16'h0, 32'd120);
    send_event(OP_ABS_X, 16'hFFFF, 32'd290);
    send_event(OP_BUTTON, 16'h0, 32'd290);
    send_event(OP_SYNC, 16'h0, 32'd300);
    // upward swipe across the timestamp wrap
    send_event(OP_ABS_X, 16'hFFFF, 32'hFFFF_FF00);
    send_event(OP_ABS_Y, 16'hFFFF, 32'hFFFF_FF00);
    send_event(OP_BUTTON, 16'h1, 32'hFFFF_FF00);
    send_event(OP_SYNC, 16'hFFFF, 32'hFFFF_FF00);
    send_event(OP_ABS_Y, 16'h0, 32'h10);
    send_event(OP_BUTTON, 16'h0, 32'h10);
    send_event(OP_SYNC, 16'h0, 32'h10);
    // zero panel maximum scales every coordinate to zero
    configure(800, 480, 0, 0, 50, 400);
    send_event(OP_ABS_X, 16'd1234, 32'd500);
    send_event(OP_ABS_Y, 16'd999, 32'd500);
    send_event(OP_BUTTON, 16'h1, 32'd500);
    send_event(OP_SYNC, 16'h0, 32'd500);
    send_event(OP_BUTTON, 16'h0, 32'd600);
    send_event(OP_SYNC, 16'h0, 32'd600);
  endtask

  // Result side: random stall before each beat, with calm stretches
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
      @(negedge clk);
    end
  end

  // Check gesture beats and end the run when nothing moves for too long
  always @(posedge clk) begin
    gesture_t got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.gesture, res_ch.point_x, res_ch.point_y};
        book.check_gesture(got);
      end
      if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    book = new();
    evt_ch.valid     = 1'b0;
    evt_ch.opcode    = '0;
    evt_ch.raw_value = '0;
    evt_ch.time_ms   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    for (int p = 0; p < 7; p++) begin
      configure(presets[p][0], presets[p][1], presets[p][2], presets[p][3],
                presets[p][4], presets[p][5]);
      run_phase();
    end
    configure($urandom_range(1, 4095), $urandom_range(1, 4095),
              $urandom_range(1, 65535), $urandom_range(1, 65535),
              $urandom_range(0, 200), $urandom_range(0, 2000));
    run_phase();

    // let the last gestures out, then allow for trailing beats
    drain_gestures();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tgc_pkg.sv
src/tgc_in_if.sv
src/tgc_out_if.sv
src/tgc_scaler.sv
src/tgc_classifier.sv
src/touch_gesture_classifier.sv
test/tb_touch_gesture_classifier.sv
